FILE: hw/rtl/mcst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcst_pkg
// Shared codes, widths and controller command type of the session timer.
// ----------------------------------------------------------------------------
package mcst_pkg;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 208;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_STOP_ALL = 3'd3;
  localparam logic [2:0] OP_QUERY    = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
  localparam logic [2:0] ST_CLOCK_BAD   = 3'd2;
  localparam logic [2:0] ST_BAD_DUR     = 3'd3;
  localparam logic [2:0] ST_BUSY        = 3'd4;
  localparam logic [2:0] ST_BAD_IDS     = 3'd5;
  localparam logic [2:0] ST_REPLAY      = 3'd6;

  localparam logic [7:0]  MIN_NONCE_LEN   = 8'd8;
  localparam logic [31:0] MAX_SESSION_RST = 32'd86400;
  localparam logic [2:0]  COUNT_SAT       = 3'd7;

  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } cmd_t;

endpackage

FILE: hw/rtl/mcst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcst_ctrl
// Sequencer: capture an item, apply it to the channel stores, load result.
// ----------------------------------------------------------------------------
module mcst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output mcst_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_t;

  state_t state;
  logic   out_valid;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && s_tvalid;
    cmd.execute  = (state == S_EXEC);
    cmd.load_out = (state == S_RESULT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/mcst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcst_datapath
// Channel stores, start checks, expiry sweep and result register.
// ----------------------------------------------------------------------------
module mcst_datapath #(
  parameter int CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mcst_pkg::cmd_t                   cmd,
  input  logic [mcst_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [2:0]                       s_tuser,
  output logic [mcst_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [2:0]                       m_tuser,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_wdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);

  // captured item
  logic [2:0]  op_q;
  logic [2:0]  ch_q;
  logic [31:0] dur_q;
  logic [31:0] now_q;
  logic        cv_q;
  logic [31:0] ntag_q;
  logic [7:0]  nlen_q;
  logic [31:0] stag_q;
  logic [7:0]  slen_q;
  logic [31:0] ptag_q;
  logic [7:0]  plen_q;

  logic [31:0] max_session_sec;

  logic [31:0] end_st   [CHANNELS];
  logic [31:0] dur_st   [CHANNELS];
  logic [31:0] nonce_st [CHANNELS];
  logic [31:0] sess_st  [CHANNELS];
  logic [31:0] pay_st   [CHANNELS];
  logic [7:0]  nlen_st  [CHANNELS];
  logic [7:0]  slen_st  [CHANNELS];

  logic [2:0]  status_q;
  logic [3:0]  expired_q;

  // result register
  logic [2:0]  r_status;
  logic [3:0]  r_relay;
  logic [3:0]  r_expired;
  logic        r_act;
  logic [31:0] r_remaining;
  logic [31:0] r_end;
  logic [31:0] r_len;
  logic [2:0]  r_count;
  logic [31:0] r_nonce;
  logic [31:0] r_sess;
  logic [31:0] r_pay;

  logic [CHANNELS-1:0] active_vec;
  logic                ok_ch;
  logic [2:0]          ch_m1;
  logic [IDX_W-1:0]    ix;
  logic [3:0]          relay;
  logic [3:0]          tick_expired;
  logic [CNT_W-1:0]    cnt;
  logic [2:0]          count_sat;
  logic [2:0]          start_status;
  logic [31:0]         end_sum;

  assign ok_ch   = (ch_q != 3'd0) && (32'(ch_q) <= 32'(CHANNELS));
  assign ch_m1   = ch_q - 3'd1;
  assign ix      = IDX_W'(ch_m1);
  assign end_sum = now_q + dur_q;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      active_vec[i] = cv_q && (end_st[i] != 32'd0) && (now_q < end_st[i]);
    end
  end

  always_comb begin
    relay = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < CHANNELS) begin
        relay[i] = active_vec[i];
      end
    end
  end

  always_comb begin
    tick_expired = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < CHANNELS) begin
        tick_expired[i] = (end_st[i] != 32'd0) && !active_vec[i];
      end
    end
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      cnt = cnt + CNT_W'(active_vec[i]);
    end
    count_sat = (32'(cnt) > 32'(mcst_pkg::COUNT_SAT)) ? mcst_pkg::COUNT_SAT : 3'(cnt);
  end

  always_comb begin
    if (!ok_ch) begin
      start_status = mcst_pkg::ST_BAD_CHANNEL;
    end else if (!cv_q) begin
      start_status = mcst_pkg::ST_CLOCK_BAD;
    end else if ((dur_q == 32'd0) || (dur_q > max_session_sec)) begin
      start_status = mcst_pkg::ST_BAD_DUR;
    end else if (active_vec[ix]) begin
      start_status = mcst_pkg::ST_BUSY;
    end else if ((nlen_q < mcst_pkg::MIN_NONCE_LEN) || (slen_q == 8'd0) ||
                 (plen_q == 8'd0)) begin
      start_status = mcst_pkg::ST_BAD_IDS;
    end else if (((nlen_st[ix] == nlen_q) && (nonce_st[ix] == ntag_q)) ||
                 ((slen_st[ix] == slen_q) && (sess_st[ix] == stag_q))) begin
      start_status = mcst_pkg::ST_REPLAY;
    end else begin
      start_status = mcst_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= s_tuser;
      ch_q   <= s_tdata[2:0];
      dur_q  <= s_tdata[34:3];
      now_q  <= s_tdata[66:35];
      cv_q   <= s_tdata[67];
      ntag_q <= s_tdata[99:68];
      nlen_q <= s_tdata[107:100];
      stag_q <= s_tdata[139:108];
      slen_q <= s_tdata[147:140];
      ptag_q <= s_tdata[179:148];
      plen_q <= s_tdata[187:180];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_session_sec <= mcst_pkg::MAX_SESSION_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        end_st[i]   <= '0;
        dur_st[i]   <= '0;
        nonce_st[i] <= '0;
        sess_st[i]  <= '0;
        pay_st[i]   <= '0;
        nlen_st[i]  <= '0;
        slen_st[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        max_session_sec <= cfg_wdata;
      end
      if (cmd.execute) begin
        case (op_q)
          mcst_pkg::OP_TICK: begin
            for (int i = 0; i < CHANNELS; i++) begin
              if ((end_st[i] != 32'd0) && !active_vec[i]) begin
                end_st[i]   <= '0;
                dur_st[i]   <= '0;
                nonce_st[i] <= '0;
                sess_st[i]  <= '0;
                pay_st[i]   <= '0;
                nlen_st[i]  <= '0;
                slen_st[i]  <= '0;
              end
            end
          end
          mcst_pkg::OP_START: begin
            if (start_status == mcst_pkg::ST_OK) begin
              end_st[ix]   <= end_sum;
              dur_st[ix]   <= dur_q;
              nonce_st[ix] <= ntag_q;
              sess_st[ix]  <= stag_q;
              pay_st[ix]   <= ptag_q;
              nlen_st[ix]  <= nlen_q;
              slen_st[ix]  <= slen_q;
            end
          end
          mcst_pkg::OP_STOP: begin
            if (ok_ch) begin
              end_st[ix]   <= '0;
              dur_st[ix]   <= '0;
              nonce_st[ix] <= '0;
              sess_st[ix]  <= '0;
              pay_st[ix]   <= '0;
              nlen_st[ix]  <= '0;
              slen_st[ix]  <= '0;
            end
          end
          mcst_pkg::OP_STOP_ALL: begin
            for (int i = 0; i < CHANNELS; i++) begin
              end_st[i]   <= '0;
              dur_st[i]   <= '0;
              nonce_st[i] <= '0;
              sess_st[i]  <= '0;
              pay_st[i]   <= '0;
              nlen_st[i]  <= '0;
              slen_st[i]  <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // status and expiry flags of the item being applied
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      case (op_q)
        mcst_pkg::OP_TICK: begin
          expired_q <= tick_expired;
          status_q  <= mcst_pkg::ST_OK;
        end
        mcst_pkg::OP_START: begin
          expired_q <= '0;
          status_q  <= start_status;
        end
        mcst_pkg::OP_STOP, mcst_pkg::OP_QUERY: begin
          expired_q <= '0;
          status_q  <= ok_ch ? mcst_pkg::ST_OK : mcst_pkg::ST_BAD_CHANNEL;
        end
        default: begin
          expired_q <= '0;
          status_q  <= mcst_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      r_status  <= status_q;
      r_relay   <= relay;
      r_expired <= expired_q;
      r_count   <= count_sat;
      if (ok_ch) begin
        r_act       <= active_vec[ix];
        r_remaining <= active_vec[ix] ? (end_st[ix] - now_q) : 32'd0;
        r_end       <= end_st[ix];
        r_len       <= dur_st[ix];
        r_nonce     <= nonce_st[ix];
        r_sess      <= sess_st[ix];
        r_pay       <= pay_st[ix];
      end else begin
        r_act       <= 1'b0;
        r_remaining <= '0;
        r_end       <= '0;
        r_len       <= '0;
        r_nonce     <= '0;
        r_sess      <= '0;
        r_pay       <= '0;
      end
    end
  end

  assign m_tuser = r_status;
  assign m_tdata = {4'd0, r_pay, r_sess, r_nonce, r_count, r_len, r_end, r_remaining,
                    r_act, r_expired, r_relay};

endmodule

FILE: hw/rtl/multi_channel_session_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_session_timer
// Per-channel timed sessions with start checks, stop, expiry tick and query.
//
//   port group  dir  tdata / tuser
//   s_*         in   item: channel, duration, time, clock flag, tags / op
//   m_*         out  result: masks, addressed channel data, count / status
//   cfg_*       in   max_session_sec write
//
// one item passes through capture, store update and result load in turn
// the result register may hold a result while the next item is captured
// a stalled result holds the result load until m_tready frees the register
// rst is synchronous; it clears all channel stores and sets the limit to 86400
// ----------------------------------------------------------------------------
module multi_channel_session_timer #(
  parameter int CHANNELS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // channel[2:0] duration_sec[34:3] now_epoch[66:35] clock_valid[67]
  // nonce_tag[99:68] nonce_len[107:100] session_tag[139:108]
  // session_len[147:140] payment_tag[179:148] payment_len[187:180]
  input  logic [191:0] s_tdata,
  // op[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // relay_mask[3:0] expired_mask[7:4] chan_active[8] remaining_sec[40:9]
  // end_time[72:41] session_length[104:73] active_count[107:105]
  // stored_nonce[139:108] stored_session[171:140] stored_payment[203:172]
  output logic [207:0] m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  mcst_pkg::cmd_t cmd;

  mcst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  mcst_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule
